// ===== design/combination_door_release_controller_core_defines.svh =====
// Assertion macros used by the checker file.
`ifndef COMBINATION_DOOR_RELEASE_CONTROLLER_CORE_DEFINES_SVH
`define COMBINATION_DOOR_RELEASE_CONTROLLER_CORE_DEFINES_SVH

// Same-cycle implication, dropped while reset is asserted.
`define CDRC_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, dropped while reset is asserted.
`define CDRC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/cdrc_pkg.sv =====
// Types, constants and helpers for the door release controller.
package cdrc_pkg;

  localparam int unsigned SWITCH_W   = 24;
  localparam int unsigned AGE_W      = 21;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  typedef logic [AGE_W-1:0] age_t;

  typedef enum logic [1:0] {
    MODE_ARMED   = 2'd0,
    MODE_OPENING = 2'd1,
    MODE_SOLVED  = 2'd2
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CORRECT_MASK    = 3'd0,
    CFG_SETTLE_TICKS    = 3'd1,
    CFG_PULSE_ON_TICKS  = 3'd2,
    CFG_PULSE_OFF_TICKS = 3'd3,
    CFG_TIMEOUT_MS      = 3'd4,
    CFG_SOLVED_WAIT     = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [SWITCH_W-1:0] correct_mask;
    logic [15:0]         settle_ticks;
    logic [15:0]         pulse_on_ticks;
    logic [15:0]         pulse_off_ticks;
    logic [19:0]         open_limit_ticks;
    logic [19:0]         solved_wait_ms;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    correct_mask:     24'd0,
    settle_ticks:     16'd50,
    pulse_on_ticks:   16'd200,
    pulse_off_ticks:  16'd800,
    open_limit_ticks: 20'd10000,
    solved_wait_ms:   20'd5000
  };

  // Debounced pins and the switch match for one tick.
  typedef struct packed {
    logic lock_bit;
    logic button_bit;
    logic all_correct;
  } sense_t;

  localparam age_t AGE_MAX = {AGE_W{1'b1}};

  function automatic age_t age_inc(input age_t a);
    age_inc = (a == AGE_MAX) ? AGE_MAX : a + age_t'(1);
  endfunction

endpackage

// ===== design/cdrc_if.sv =====
// Channel interfaces: tick input, result output and configuration write.
interface cdrc_tick_if
  import cdrc_pkg::*;
();
  logic                valid;
  logic                ready;
  logic                lock_pin;
  logic                button_pin;
  logic [SWITCH_W-1:0] switch_pins;

  modport source (output valid, lock_pin, button_pin, switch_pins, input ready);
  modport sink   (input valid, lock_pin, button_pin, switch_pins, output ready);
endinterface

interface cdrc_result_if;
  logic       valid;
  logic       ready;
  logic       relay_drive;
  logic [1:0] machine_state;
  logic       all_correct;
  logic       lock_bit;
  logic       button_bit;

  modport source (output valid, relay_drive, machine_state, all_correct, lock_bit,
                  button_bit, input ready);
  modport sink   (input valid, relay_drive, machine_state, all_correct, lock_bit,
                  button_bit, output ready);
endinterface

interface cdrc_cfg_if
  import cdrc_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/cdrc_debounce.sv =====
// Debouncer for one pin: last level plus a saturating stable-age counter.
module cdrc_debounce
  import cdrc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic        pin_i,
  input  logic [15:0] settle_ticks_i,
  output logic        bit_o
);

  logic last_q, last_d;
  age_t age_q, age_d;

  always_comb begin
    if (pin_i != last_q) begin
      last_d = pin_i;
      age_d  = '0;
    end else begin
      last_d = last_q;
      age_d  = age_inc(age_q);
    end
    bit_o = (age_d > {{(AGE_W-16){1'b0}}, settle_ticks_i}) ? last_d : 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= 1'b0;
      age_q  <= '0;
    end else if (step_i) begin
      last_q <= last_d;
      age_q  <= age_d;
    end
  end

endmodule

// ===== design/cdrc_ctrl.sv =====
// Armed / opening / solved-wait state machine with relay pulse timing.
module cdrc_ctrl
  import cdrc_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   step_i,
  input  sense_t sense_i,
  input  cfg_t   cfg_i,
  output logic   relay_o,
  output mode_e  mode_o
);

  mode_e mode_q, mode_d;
  age_t  open_age_q, open_age_d;
  age_t  pulse_age_q, pulse_age_d;
  age_t  wait_age_q, wait_age_d;
  logic  pulse_started_q, pulse_started_d;
  logic  relay_q, relay_d;
  logic [16:0] period;

  assign period = {1'b0, cfg_i.pulse_on_ticks} + {1'b0, cfg_i.pulse_off_ticks};

  always_comb begin
    mode_d          = mode_q;
    open_age_d      = open_age_q;
    pulse_age_d     = pulse_age_q;
    wait_age_d      = wait_age_q;
    pulse_started_d = pulse_started_q;
    relay_d         = relay_q;

    case (mode_q)
      MODE_OPENING: begin
        if (!pulse_started_q) begin
          pulse_started_d = 1'b1;
          pulse_age_d     = '0;
        end
        if (!sense_i.lock_bit ||
            open_age_q > {{(AGE_W-20){1'b0}}, cfg_i.open_limit_ticks}) begin
          relay_d    = 1'b0;
          mode_d     = MODE_SOLVED;
          wait_age_d = '0;
        end else begin
          // restart the pulse once a full on+off period has run
          if (pulse_age_d > {{(AGE_W-17){1'b0}}, period}) begin
            pulse_age_d = '0;
            relay_d     = 1'b1;
          end
          if (pulse_age_d > {{(AGE_W-16){1'b0}}, cfg_i.pulse_on_ticks}) begin
            relay_d = 1'b0;
          end
          open_age_d = age_inc(open_age_q);
        end
      end
      MODE_SOLVED: begin
        if (wait_age_q >= {{(AGE_W-20){1'b0}}, cfg_i.solved_wait_ms}) begin
          mode_d = MODE_ARMED;
        end else begin
          wait_age_d = age_inc(wait_age_q);
        end
      end
      default: begin
        mode_d = MODE_ARMED;
        if (sense_i.all_correct || sense_i.button_bit) begin
          mode_d     = MODE_OPENING;
          open_age_d = '0;
        end
      end
    endcase

    if (pulse_started_d) begin
      pulse_age_d = age_inc(pulse_age_d);
    end

    relay_o = relay_d;
    mode_o  = mode_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q          <= MODE_ARMED;
      open_age_q      <= '0;
      pulse_age_q     <= '0;
      wait_age_q      <= '0;
      pulse_started_q <= 1'b0;
      relay_q         <= 1'b0;
    end else if (step_i) begin
      mode_q          <= mode_d;
      open_age_q      <= open_age_d;
      pulse_age_q     <= pulse_age_d;
      wait_age_q      <= wait_age_d;
      pulse_started_q <= pulse_started_d;
      relay_q         <= relay_d;
    end
  end

endmodule

// ===== design/combination_door_release_controller_core.sv =====
// Top level of the combination door release controller.
//
//   channel   dir  handshake     word
//   tick_i    in   valid/ready   lock_pin, button_pin, switch_pins
//   result_o  out  valid/ready   relay_drive, machine_state, all_correct,
//                                lock_bit, button_bit
//   cfg_i     in   valid/ready   index, data (always ready)
//
// A tick word is registered on acceptance and its step runs when it advances
// into the result register, one word per cycle while the result is not stalled.
// The step is a debounce compare, a match of up to 24 switch bits and the state update.
// Reset clears valid flags, debounce and controller state and loads the
// configuration defaults. A stalled result holds; the input stage keeps
// accepting while the result register can drain.
module combination_door_release_controller_core
  import cdrc_pkg::*;
#(
  parameter int unsigned SWITCH_COUNT = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  cdrc_tick_if.sink   tick_i,
  cdrc_result_if.source result_o,
  cdrc_cfg_if.sink    cfg_i
);

  localparam int unsigned CMP_W = (SWITCH_COUNT < SWITCH_W) ? SWITCH_COUNT : SWITCH_W;

  cfg_t cfg_q;

  logic                s1_valid_q;
  logic                s1_lock_q;
  logic                s1_button_q;
  logic [SWITCH_W-1:0] s1_switch_q;

  logic       out_valid_q;
  logic       out_relay_q;
  logic [1:0] out_state_q;
  sense_t     out_sense_q;

  logic   advance;
  logic   tick_acc;
  sense_t sense;
  logic   relay_next;
  mode_e  mode_next;

  assign advance      = s1_valid_q && (!out_valid_q || result_o.ready);
  assign tick_i.ready = !s1_valid_q || advance;
  assign tick_acc     = tick_i.valid && tick_i.ready;
  assign cfg_i.ready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_CORRECT_MASK:    cfg_q.correct_mask     <= cfg_i.data;
        CFG_SETTLE_TICKS:    cfg_q.settle_ticks     <= cfg_i.data[15:0];
        CFG_PULSE_ON_TICKS:  cfg_q.pulse_on_ticks   <= cfg_i.data[15:0];
        CFG_PULSE_OFF_TICKS: cfg_q.pulse_off_ticks  <= cfg_i.data[15:0];
        CFG_TIMEOUT_MS:      cfg_q.open_limit_ticks <= cfg_i.data[19:0];
        CFG_SOLVED_WAIT:     cfg_q.solved_wait_ms   <= cfg_i.data[19:0];
        default: ;
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (tick_acc) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick_acc) begin
      s1_lock_q   <= tick_i.lock_pin;
      s1_button_q <= tick_i.button_pin;
      s1_switch_q <= tick_i.switch_pins;
    end
  end

  cdrc_debounce u_lock_db (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (advance),
    .pin_i          (s1_lock_q),
    .settle_ticks_i (cfg_q.settle_ticks),
    .bit_o          (sense.lock_bit)
  );

  cdrc_debounce u_button_db (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (advance),
    .pin_i          (s1_button_q),
    .settle_ticks_i (cfg_q.settle_ticks),
    .bit_o          (sense.button_bit)
  );

  // switches are active low; only the populated ones take part
  assign sense.all_correct = ((~s1_switch_q[CMP_W-1:0]) == cfg_q.correct_mask[CMP_W-1:0]);

  cdrc_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .sense_i (sense),
    .cfg_i   (cfg_q),
    .relay_o (relay_next),
    .mode_o  (mode_next)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_relay_q <= relay_next;
      out_state_q <= mode_next;
      out_sense_q <= sense;
    end
  end

  assign result_o.valid         = out_valid_q;
  assign result_o.relay_drive   = out_relay_q;
  assign result_o.machine_state = out_state_q;
  assign result_o.all_correct   = out_sense_q.all_correct;
  assign result_o.lock_bit      = out_sense_q.lock_bit;
  assign result_o.button_bit    = out_sense_q.button_bit;

endmodule

// ===== design/cdrc_assert.sv =====
// Port-level assertions for the door release controller, bound to the top.
`include "combination_door_release_controller_core_defines.svh"

module cdrc_assert
  import cdrc_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       tick_valid_i,
  input logic       tick_ready_i,
  input logic       res_valid_i,
  input logic       res_ready_i,
  input logic       res_relay_i,
  input logic [1:0] res_state_i,
  input logic       res_correct_i,
  input logic       res_lock_i,
  input logic       res_button_i
);

  logic       tick_acc;
  logic [5:0] res_word;
  assign tick_acc = tick_valid_i && tick_ready_i;
  assign res_word = {res_relay_i, res_state_i, res_correct_i, res_lock_i, res_button_i};

  // the relay can only be energized while opening
  `CDRC_ASSERT_NOW(a_relay_only_opening, clk_i, rst_ni,
                   res_valid_i && res_relay_i, res_state_i == MODE_OPENING,
                   "relay energized outside opening")

  // a draining result side never stalls the tick side
  `CDRC_ASSERT_NOW(a_ready_passes, clk_i, rst_ni, res_ready_i, tick_ready_i,
                   "tick side stalled while result side ready")

  // an accepted tick is always followed by a valid result past the input stage and result register
  `CDRC_ASSERT_NOW(a_latency, clk_i, rst_ni, tick_acc, ##2 res_valid_i,
                   "no result two cycles after tick")

  // a stalled result word holds
  `CDRC_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, res_valid_i && !res_ready_i,
                    res_valid_i && $stable(res_word), "stalled result changed")

endmodule

bind combination_door_release_controller_core cdrc_assert u_cdrc_assert (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .tick_valid_i  (tick_i.valid),
  .tick_ready_i  (tick_i.ready),
  .res_valid_i   (result_o.valid),
  .res_ready_i   (result_o.ready),
  .res_relay_i   (result_o.relay_drive),
  .res_state_i   (result_o.machine_state),
  .res_correct_i (result_o.all_correct),
  .res_lock_i    (result_o.lock_bit),
  .res_button_i  (result_o.button_bit)
);

// ===== tb/sv/door_release_tb_pkg.sv =====
// Scoreboard for the door release controller: tick predictor and result checks.
package door_release_tb_pkg;
  import cdrc_pkg::*;

  // Register indexes the block does not decode; writes to them are dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  localparam int LOCK_CH   = 0;
  localparam int BUTTON_CH = 1;

  typedef struct packed {
    logic       relay;
    logic [1:0] state;
    logic       match;
    logic       lock_b;
    logic       button_b;
  } door_result_t;

  class door_release_scoreboard;
    cfg_t                regs;
    mode_e               mode;
    logic                pin_last [2];
    logic [AGE_W-1:0]    pin_age  [2];
    logic [AGE_W-1:0]    open_age;
    logic [AGE_W-1:0]    pulse_age;
    logic [AGE_W-1:0]    wait_age;
    logic                pulse_started;
    logic                relay;
    door_result_t        expected_q [$];
    int                  failures;

    function new();
      regs          = CFG_RESET;
      mode          = MODE_ARMED;
      pin_last      = '{1'b0, 1'b0};
      pin_age       = '{'0, '0};
      open_age      = '0;
      pulse_age     = '0;
      wait_age      = '0;
      pulse_started = 1'b0;
      relay         = 1'b0;
      failures      = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
      case (index)
        CFG_CORRECT_MASK:    regs.correct_mask     = data[SWITCH_W-1:0];
        CFG_SETTLE_TICKS:    regs.settle_ticks     = data[15:0];
        CFG_PULSE_ON_TICKS:  regs.pulse_on_ticks   = data[15:0];
        CFG_PULSE_OFF_TICKS: regs.pulse_off_ticks  = data[15:0];
        CFG_TIMEOUT_MS:      regs.open_limit_ticks = data[19:0];
        CFG_SOLVED_WAIT:     regs.solved_wait_ms   = data[19:0];
        default: ;
      endcase
    endfunction

    // Saturate at the top of the counter range.
    function logic [AGE_W-1:0] bump_age(logic [AGE_W-1:0] a);
      return (a == '1) ? a : a + 1'b1;
    endfunction

    function logic settle(int ch, logic pin);
      if (pin != pin_last[ch]) begin
        pin_last[ch] = pin;
        pin_age[ch]  = '0;
      end else begin
        pin_age[ch] = bump_age(pin_age[ch]);
      end
      return (pin_age[ch] > regs.settle_ticks) ? pin_last[ch] : 1'b0;
    endfunction

    function void note_tick(logic lk, logic bt, logic [SWITCH_W-1:0] sw);
      door_result_t        res;
      logic                lock_b;
      logic                button_b;
      logic                match;
      logic [SWITCH_W-1:0] active;
      logic [16:0]         period;
      lock_b   = settle(LOCK_CH, lk);
      button_b = settle(BUTTON_CH, bt);
      active   = ~sw;
      match    = (active == regs.correct_mask);
      period   = {1'b0, regs.pulse_on_ticks} + {1'b0, regs.pulse_off_ticks};
      case (mode)
        MODE_OPENING: begin
          if (!pulse_started) begin
            pulse_started = 1'b1;
            pulse_age     = '0;
          end
          if (!lock_b || open_age > regs.open_limit_ticks) begin
            relay    = 1'b0;
            mode     = MODE_SOLVED;
            wait_age = '0;
          end else begin
            if (pulse_age > period) begin
              pulse_age = '0;
              relay     = 1'b1;
            end
            if (pulse_age > regs.pulse_on_ticks) relay = 1'b0;
            open_age = bump_age(open_age);
          end
        end
        MODE_SOLVED: begin
          if (wait_age >= regs.solved_wait_ms) mode = MODE_ARMED;
          else wait_age = bump_age(wait_age);
        end
        default: begin
          mode = MODE_ARMED;
          if (match || button_b) begin
            mode     = MODE_OPENING;
            open_age = '0;
          end
        end
      endcase
      if (pulse_started) pulse_age = bump_age(pulse_age);
      res.relay    = relay;
      res.state    = mode;
      res.match    = match;
      res.lock_b   = lock_b;
      res.button_b = button_b;
      expected_q.push_back(res);
    endfunction

    function void check_result(door_result_t got);
      door_result_t exp;
      if (expected_q.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("%0t: unexpected word relay=%0d state=%0d match=%0d lock=%0d button=%0d",
                   $time, got.relay, got.state, got.match, got.lock_b, got.button_b);
        return;
      end
      exp = expected_q.pop_front();
      if (got.relay !== exp.relay || got.state !== exp.state || got.match !== exp.match ||
          got.lock_b !== exp.lock_b || got.button_b !== exp.button_b) begin
        failures++;
        if (failures <= 10) begin
          $display("%0t: mismatch expected relay=%0d state=%0d match=%0d lock=%0d button=%0d",
                   $time, exp.relay, exp.state, exp.match, exp.lock_b, exp.button_b);
          $display("%0t:          actual   relay=%0d state=%0d match=%0d lock=%0d button=%0d",
                   $time, got.relay, got.state, got.match, got.lock_b, got.button_b);
        end
      end
    endfunction
  endclass

endpackage

// ===== tb/sv/testbench.sv =====
// Top-level testbench for the door release controller core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import cdrc_pkg::*;
  import door_release_tb_pkg::*;

  localparam int IDLE_PCT    = 14;
  localparam int STALL_LIMIT = 1000;
  localparam int PHASES      = 12;
  localparam int PHASE_TICKS = 155;

  logic clk_i = 1'b0;
  logic rst_ni;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  cdrc_tick_if   tick ();
  cdrc_result_if result ();
  cdrc_cfg_if    cfg ();

  combination_door_release_controller_core dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tick_i   (tick),
    .result_o (result),
    .cfg_i    (cfg)
  );

  door_release_scoreboard sb;
  bit                     steady = 1'b0;
  int                     quiet_cycles = 0;
  logic [CFG_DATA_W-1:0]  set_mask, set_dbn, set_on, set_off, set_tmo, set_wait;

  // Watchdog: give up when no channel moves a word for too long.
  always @(posedge clk_i) begin
    if ((tick.valid && tick.ready) || (result.valid && result.ready) ||
        (cfg.valid && cfg.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result sink: check each accepted word, stall at random.
  always @(posedge clk_i) begin
    if (result.valid && result.ready)
      sb.check_result('{relay: result.relay_drive, state: result.machine_state,
                        match: result.all_correct, lock_b: result.lock_bit,
                        button_b: result.button_bit});
    result.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  task automatic send_tick(logic lk, logic bt, logic [SWITCH_W-1:0] sw);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      tick.valid <= 1'b0;
      @(posedge clk_i);
    end
    tick.valid       <= 1'b1;
    tick.lock_pin    <= lk;
    tick.button_pin  <= bt;
    tick.switch_pins <= sw;
    @(posedge clk_i);
    while (!tick.ready) @(posedge clk_i);
    sb.note_tick(lk, bt, sw);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= index;
    cfg.data  <= data;
    @(posedge clk_i);
    while (!cfg.ready) @(posedge clk_i);
    sb.set_reg(index, data);
    cfg.valid <= 1'b0;
  endtask

  // Drop valid and let every outstanding word come back.
  task automatic drain();
    tick.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Mostly stable pin runs of random length, some long enough to pass the debouncer, some noise.
  task automatic random_runs(int count);
    int                  left;
    int                  run_len;
    int                  cap;
    bit                  noisy;
    logic                lk;
    logic                bt;
    logic [SWITCH_W-1:0] sw;
    left = count;
    while (left > 0) begin
      noisy   = ($urandom_range(99) < 25);
      cap     = (sb.regs.settle_ticks > 28) ? 40 : int'(sb.regs.settle_ticks) + 12;
      run_len = noisy ? $urandom_range(4, 1) : $urandom_range(cap, 1);
      if (run_len > left) run_len = left;
      lk = ($urandom_range(99) < 80);
      bt = ($urandom_range(99) < 35);
      case ($urandom_range(3))
        0, 1:    sw = ~sb.regs.correct_mask;
        2:       sw = ~sb.regs.correct_mask ^ (SWITCH_W'(1) << $urandom_range(SWITCH_W-1));
        default: sw = SWITCH_W'($urandom);
      endcase
      repeat (run_len) begin
        if (noisy) begin
          lk = 1'($urandom_range(1));
          bt = 1'($urandom_range(1));
          sw = SWITCH_W'($urandom);
        end
        send_tick(lk, bt, sw);
      end
      left -= run_len;
    end
  endtask

  initial begin
    sb = new();
    rst_ni           <= 1'b0;
    tick.valid       <= 1'b0;
    tick.lock_pin    <= 1'b0;
    tick.button_pin  <= 1'b0;
    tick.switch_pins <= '0;
    cfg.valid        <= 1'b0;
    cfg.index        <= '0;
    cfg.data         <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Defaults: all switches inactive match the zero mask, field extremes.
    send_tick(1'b0, 1'b0, '1);
    send_tick(1'b1, 1'b1, '0);
    send_tick(1'b1, 1'b0, 24'h555555);
    send_tick(1'b0, 1'b1, 24'hAAAAAA);
    send_tick(1'b1, 1'b1, '1);
    send_tick(1'b1, 1'b1, 24'h000001);
    drain();

    // Short timings: match opens, relay pulses, timeout closes, solved re-arms.
    write_reg(CFG_CORRECT_MASK, 24'h800001);
    write_reg(CFG_SETTLE_TICKS, 24'd0);
    write_reg(CFG_PULSE_ON_TICKS, 24'd1);
    write_reg(CFG_PULSE_OFF_TICKS, 24'd1);
    write_reg(CFG_TIMEOUT_MS, 24'd6);
    write_reg(CFG_SOLVED_WAIT, 24'd2);
    repeat (12) send_tick(1'b1, 1'b0, 24'h7FFFFE);
    drain();

    // Undecoded indexes must leave every register alone.
    write_reg(CFG_SPARE_LO, '1);
    write_reg(CFG_SPARE_HI, '1);
    send_tick(1'b1, 1'b0, 24'h7FFFFE);
    send_tick(1'b0, 1'b0, 24'h7FFFFE);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      steady = (p == 3 || p == 4);
      case (p)
        0: begin
          set_mask = '0; set_dbn = '0; set_on = '0;
          set_off  = '0; set_tmo = '0; set_wait = '0;
        end
        1: begin
          set_mask = '1; set_dbn = '1; set_on = '1;
          set_off  = '1; set_tmo = '1; set_wait = '1;
        end
        default: begin
          // Upper bits beyond each register's width are junk and must be ignored.
          set_mask = CFG_DATA_W'($urandom);
          set_dbn  = {8'($urandom), 16'($urandom_range(6))};
          set_on   = {8'($urandom), 16'($urandom_range(12))};
          set_off  = {8'($urandom), 16'($urandom_range(12))};
          set_tmo  = {4'($urandom), 20'($urandom_range(80))};
          set_wait = {4'($urandom), 20'($urandom_range(40))};
        end
      endcase
      write_reg(CFG_CORRECT_MASK, set_mask);
      write_reg(CFG_SETTLE_TICKS, set_dbn);
      write_reg(CFG_PULSE_ON_TICKS, set_on);
      write_reg(CFG_PULSE_OFF_TICKS, set_off);
      write_reg(CFG_TIMEOUT_MS, set_tmo);
      write_reg(CFG_SOLVED_WAIT, set_wait);
      if (p % 4 == 2) write_reg(CFG_SPARE_HI, CFG_DATA_W'($urandom));
      random_runs(PHASE_TICKS);
    end

    drain();
    repeat (4) @(posedge clk_i);
    if (sb.failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
